// File: design/source_text_tokenizer_unit_macros.svh
// Assertion helpers for the tokenizer checker.
// Both expect signals named clk and arst_n in the scope of use.
`ifndef SOURCE_TEXT_TOKENIZER_UNIT_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_UNIT_MACROS_SVH

// Property checked outside reset.
`define STL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Property checked at every edge, reset included.
`define STL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

// File: design/stl_pkg.sv
`timescale 1ns / 1ps

package stl_pkg;

	localparam int POS_BITS_DEF = 16;
	localparam int OUT_W        = 16;
	localparam int MAX_RES      = 3;
	localparam int NUM_KW       = 5;

	// token kinds
	localparam logic [4:0] K_END    = 5'd0;
	localparam logic [4:0] K_INT    = 5'd1;
	localparam logic [4:0] K_PRINT  = 5'd2;
	localparam logic [4:0] K_IF     = 5'd3;
	localparam logic [4:0] K_STRING = 5'd4;
	localparam logic [4:0] K_ARRAY  = 5'd5;
	localparam logic [4:0] K_IDENT  = 5'd6;
	localparam logic [4:0] K_NUMBER = 5'd7;
	localparam logic [4:0] K_ASSIGN = 5'd8;
	localparam logic [4:0] K_EQ     = 5'd9;
	localparam logic [4:0] K_LT     = 5'd10;
	localparam logic [4:0] K_LE     = 5'd11;
	localparam logic [4:0] K_GT     = 5'd12;
	localparam logic [4:0] K_GE     = 5'd13;
	localparam logic [4:0] K_PLUS   = 5'd14;
	localparam logic [4:0] K_MINUS  = 5'd15;
	localparam logic [4:0] K_STAR   = 5'd16;
	localparam logic [4:0] K_SLASH  = 5'd17;
	localparam logic [4:0] K_SEMI   = 5'd18;
	localparam logic [4:0] K_LPAREN = 5'd19;
	localparam logic [4:0] K_RPAREN = 5'd20;
	localparam logic [4:0] K_LBRACE = 5'd21;
	localparam logic [4:0] K_RBRACE = 5'd22;
	localparam logic [4:0] K_LBRACK = 5'd23;
	localparam logic [4:0] K_RBRACK = 5'd24;
	localparam logic [4:0] K_COMMA  = 5'd25;
	localparam logic [4:0] K_STRLIT = 5'd26;

	// keyword text, first character in the top byte
	localparam logic [47:0] KW_TEXT [NUM_KW] = '{
		{"int", 24'h0}, {"print", 8'h0}, {"if", 32'h0}, "string", {"array", 8'h0}
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd5, 3'd2, 3'd6, 3'd5};
	localparam logic [4:0] KW_KIND [NUM_KW] = '{K_INT, K_PRINT, K_IF, K_STRING, K_ARRAY};

	typedef enum logic [6:0] {
		M_IDLE  = 7'b0000001,
		M_IDENT = 7'b0000010,
		M_NUM   = 7'b0000100,
		M_EQ    = 7'b0001000,
		M_LT    = 7'b0010000,
		M_GT    = 7'b0100000,
		M_STR   = 7'b1000000
	} mode_t;

	typedef struct packed {
		logic [4:0]       kind;
		logic [OUT_W-1:0] start;
		logic [OUT_W-1:0] length;
		logic             last;
	} tok_t;

	// all tokens one byte produces
	typedef struct packed {
		tok_t [MAX_RES-1:0] tok;
		logic [1:0]         count;
	} res_bundle_t;

	// keywords that still match after character k of the identifier is b
	function automatic logic [NUM_KW-1:0] kw_match(input logic [NUM_KW-1:0] cand,
		input logic k_ok, input logic [2:0] k, input logic [7:0] b);
		logic [NUM_KW-1:0] m;
		logic [47:0] sh;
		m = '0;
		for (int i = 0; i < NUM_KW; i++) begin
			sh = KW_TEXT[i] << {k, 3'b000};
			if (cand[i] && k_ok && (k < KW_LEN[i]) && (sh[47:40] == b))
				m[i] = 1'b1;
		end
		return m;
	endfunction

	function automatic logic [4:0] punct_kind(input logic [7:0] b);
		logic [4:0] k;
		case (b)
			"+":     k = K_PLUS;
			"-":     k = K_MINUS;
			"*":     k = K_STAR;
			"/":     k = K_SLASH;
			";":     k = K_SEMI;
			"(":     k = K_LPAREN;
			")":     k = K_RPAREN;
			"{":     k = K_LBRACE;
			"}":     k = K_RBRACE;
			"[":     k = K_LBRACK;
			"]":     k = K_RBRACK;
			",":     k = K_COMMA;
			default: k = K_END;
		endcase
		return k;
	endfunction

endpackage

// File: design/stl_if.sv
`timescale 1ns / 1ps

interface stl_text_if import stl_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, text_byte, end_of_text, input ready);
	modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface stl_token_if import stl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [4:0]       token_kind;
	logic [OUT_W-1:0] token_start;
	logic [OUT_W-1:0] token_length;
	logic             last_of_run;

	modport source (output valid, token_kind, token_start, token_length, last_of_run,
		input ready);
	modport sink (input valid, token_kind, token_start, token_length, last_of_run,
		output ready);
endinterface

// File: design/source_text_tokenizer_unit.sv
`timescale 1ns / 1ps
// Streaming tokenizer for a small language.
// text carries one source byte per transfer, end_of_text marks the last one.
// tokens carries tokens as kind, start offset and length; last_of_run is set
// on the final token caused by one input byte (up to three tokens per byte).
// An accepted byte lands in an input register; once the result buffer is free,
// the lexer state machine updates and the tokens for that byte load into the
// result buffer, whose registers then offer them on tokens one at a time.
// Throughput: one byte per cycle while each byte gives at most one token and
// tokens does not stall; a byte giving more tokens holds the result buffer
// until the last of them transfers. Bytes giving no token never occupy it.
// Reset clears the position counter and lexer state; offsets restart at zero,
// and also after each end token. When tokens stalls, the result buffer
// holds its tokens, the input register fills, and text.ready drops.
module source_text_tokenizer_unit import stl_pkg::*; #(
	parameter int POS_BITS = POS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	stl_text_if.sink    text,
	stl_token_if.source tokens
);

	logic        valid_s1;
	logic [7:0]  text_byte_s1;
	logic        end_of_text_s1;
	logic        advance;
	logic        free;
	res_bundle_t res;

	assign advance    = valid_s1 && free;
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			text_byte_s1   <= text.text_byte;
			end_of_text_s1 <= text.end_of_text;
		end
	end

	stl_lexer #(
		.POS_BITS(POS_BITS)
	) u_lexer (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.text_byte_s1   (text_byte_s1),
		.end_of_text_s1 (end_of_text_s1),
		.res            (res)
	);

	stl_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.res    (res),
		.free   (free),
		.tokens (tokens)
	);

endmodule

// File: design/stl_lexer.sv
`timescale 1ns / 1ps

module stl_lexer import stl_pkg::*; #(
	parameter int POS_BITS = POS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic [7:0]  text_byte_s1,
	input  logic        end_of_text_s1,
	output res_bundle_t res
);

	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	mode_t               mode_q, mode_n;
	logic [POS_BITS-1:0] pos_q, pos_n;
	logic [POS_BITS-1:0] tb_q, tb_n;
	logic [NUM_KW-1:0]   kc_q, kc_n;

	logic [POS_BITS-1:0] np, span_p, span_np, offs;
	logic                consumed;
	logic [7:0]          b;
	logic [4:0]          pk, opk;
	tok_t                cand [4];
	logic [3:0]          cv;
	logic [1:0]          n;

	function automatic logic [OUT_W-1:0] sat16(input logic [POS_BITS-1:0] v);
		logic [32:0] w;
		w = 33'(v);
		return (w > 33'h0FFFF) ? '1 : w[OUT_W-1:0];
	endfunction

	function automatic tok_t mk(input logic [4:0] kind, input logic [POS_BITS-1:0] start,
		input logic [POS_BITS-1:0] len);
		tok_t t;
		t.kind   = kind;
		t.start  = sat16(start);
		t.length = sat16(len);
		t.last   = 1'b0;
		return t;
	endfunction

	function automatic logic [4:0] ident_kind(input logic [NUM_KW-1:0] kc,
		input logic [POS_BITS-1:0] len);
		logic [4:0] k;
		logic       short_len;
		k = K_IDENT;
		short_len = (len >> 3) == '0;
		for (int i = NUM_KW - 1; i >= 0; i--)
			if (kc[i] && short_len && len[2:0] == KW_LEN[i])
				k = KW_KIND[i];
		return k;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	always_comb begin
		b        = text_byte_s1;
		mode_n   = mode_q;
		tb_n     = tb_q;
		kc_n     = kc_q;
		consumed = 1'b1;
		cv       = '0;
		for (int j = 0; j < 4; j++)
			cand[j] = '0;
		np      = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
		offs    = pos_q - tb_q;
		span_p  = (pos_q >= tb_q) ? offs : '0;
		span_np = '0;
		pk      = punct_kind(b);
		opk     = K_ASSIGN;

		// close or extend the pending token
		unique case (mode_q)
			M_IDENT: begin
				if (is_alpha(b) || is_digit(b)) begin
					kc_n = (pos_q == POS_MAX) ? '0
						: kw_match(kc_q, (offs >> 3) == '0, offs[2:0], b);
				end else begin
					cv[0]    = 1'b1;
					cand[0]  = mk(ident_kind(kc_q, span_p), tb_q, span_p);
					mode_n   = M_IDLE;
					consumed = 1'b0;
				end
			end
			M_NUM: begin
				if (!is_digit(b)) begin
					cv[0]    = 1'b1;
					cand[0]  = mk(K_NUMBER, tb_q, span_p);
					mode_n   = M_IDLE;
					consumed = 1'b0;
				end
			end
			M_EQ, M_LT, M_GT: begin
				opk = (mode_q == M_EQ) ? K_ASSIGN : ((mode_q == M_LT) ? K_LT : K_GT);
				cv[0] = 1'b1;
				if (b == "=") begin
					cand[0] = mk(opk + 5'd1, tb_q, POS_BITS'(2));
				end else begin
					cand[0]  = mk(opk, tb_q, POS_BITS'(1));
					consumed = 1'b0;
				end
				mode_n = M_IDLE;
			end
			M_STR: begin
				// a zero byte cuts the literal and is dropped
				if (b == "\"" || b == 8'd0) begin
					cv[0]   = 1'b1;
					cand[0] = mk(K_STRLIT, tb_q, span_p);
					mode_n  = M_IDLE;
				end
			end
			default: begin
				mode_n   = M_IDLE;
				consumed = 1'b0;
			end
		endcase

		// byte not absorbed: it may open a new token
		if (!consumed && !is_space(b)) begin
			if (is_alpha(b)) begin
				mode_n = M_IDENT;
				tb_n   = pos_q;
				kc_n   = kw_match('1, 1'b1, 3'd0, b);
			end else if (is_digit(b)) begin
				mode_n = M_NUM;
				tb_n   = pos_q;
			end else if (b == "=") begin
				mode_n = M_EQ;
				tb_n   = pos_q;
			end else if (b == "<") begin
				mode_n = M_LT;
				tb_n   = pos_q;
			end else if (b == ">") begin
				mode_n = M_GT;
				tb_n   = pos_q;
			end else if (b == "\"") begin
				mode_n = M_STR;
				tb_n   = np;
			end else if (pk != K_END) begin
				cv[1]   = 1'b1;
				cand[1] = mk(pk, pos_q, POS_BITS'(1));
			end
		end

		if (end_of_text_s1) begin
			span_np = (np >= tb_n) ? np - tb_n : '0;
			cv[2]   = (mode_n != M_IDLE);
			unique case (mode_n)
				M_IDENT: cand[2] = mk(ident_kind(kc_n, span_np), tb_n, span_np);
				M_NUM:   cand[2] = mk(K_NUMBER, tb_n, span_np);
				M_EQ:    cand[2] = mk(K_ASSIGN, tb_n, POS_BITS'(1));
				M_LT:    cand[2] = mk(K_LT, tb_n, POS_BITS'(1));
				M_GT:    cand[2] = mk(K_GT, tb_n, POS_BITS'(1));
				M_STR:   cand[2] = mk(K_STRLIT, tb_n, span_np);
				default: cand[2] = '0;
			endcase
			cv[3]   = 1'b1;
			cand[3] = mk(K_END, np, '0);
			mode_n  = M_IDLE;
			tb_n    = '0;
			kc_n    = '0;
			pos_n   = '0;
		end else begin
			pos_n = np;
		end

		// pack present tokens in order
		res = '0;
		n   = 2'd0;
		for (int j = 0; j < 4; j++) begin
			if (cv[j] && n != 2'd3) begin
				res.tok[n] = cand[j];
				n = n + 2'd1;
			end
		end
		res.count = n;
		for (int j = 0; j < MAX_RES; j++)
			res.tok[j].last = (n != 2'd0) && (2'(j) == n - 2'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pos_q  <= '0;
			tb_q   <= '0;
			kc_q   <= '0;
		end else if (advance) begin
			mode_q <= mode_n;
			pos_q  <= pos_n;
			tb_q   <= tb_n;
			kc_q   <= kc_n;
		end
	end

endmodule

// File: design/stl_outbuf.sv
`timescale 1ns / 1ps

module stl_outbuf import stl_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  res_bundle_t    res,
	output logic           free,
	stl_token_if.source    tokens
);

	tok_t [MAX_RES-1:0] tok_q;
	logic [1:0]         cnt_q;
	logic [1:0]         idx_q;
	logic               xfer;
	tok_t               cur;

	assign tokens.valid = (idx_q != cnt_q);
	assign xfer         = tokens.valid && tokens.ready;
	// the buffer can take the next group when empty or once its last token is leaving
	assign free = !tokens.valid || (xfer && idx_q == cnt_q - 2'd1);

	always_comb begin
		cur = tok_q[0];
		if (idx_q != 2'd3)
			cur = tok_q[idx_q];
	end

	assign tokens.token_kind   = cur.kind;
	assign tokens.token_start  = cur.start;
	assign tokens.token_length = cur.length;
	assign tokens.last_of_run  = cur.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res.count;
			idx_q <= 2'd0;
		end else if (xfer) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			tok_q <= res.tok;
	end

endmodule

// File: design/stl_checker.sv
`timescale 1ns / 1ps
`include "source_text_tokenizer_unit_macros.svh"

module stl_checker import stl_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             tok_valid,
	input logic             tok_ready,
	input logic [4:0]       tok_kind,
	input logic [OUT_W-1:0] tok_start,
	input logic [OUT_W-1:0] tok_length,
	input logic             tok_last
);

	// stalled token is held
	`STL_ASSERT(a_out_hold, tok_valid && !tok_ready |=> tok_valid && $stable(tok_kind) && $stable(tok_start) && $stable(tok_length), "token changed while stalled")

	// end token closes its run and has no text
	`STL_ASSERT(a_end_last, tok_valid && tok_kind == K_END |-> tok_last && tok_length == '0, "end token malformed")

	`STL_ASSERT(a_kind_range, tok_valid |-> tok_kind <= K_STRLIT, "token kind out of range")

	// nothing is offered while in reset
	`STL_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !tok_valid, "token offered during reset")

endmodule

bind source_text_tokenizer_unit stl_checker u_stl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tok_valid  (tokens.valid),
	.tok_ready  (tokens.ready),
	.tok_kind   (tokens.token_kind),
	.tok_start  (tokens.token_start),
	.tok_length (tokens.token_length),
	.tok_last   (tokens.last_of_run)
);

// File: tb/tb_source_text_tokenizer_unit.sv
`timescale 1ns / 1ps

module tb_source_text_tokenizer_unit;
	import stl_pkg::*;

	localparam int POS_SAT        = (1 << POS_BITS_DEF) - 1;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_BYTES   = 500;
	localparam int CALM_FROM      = 400;

	class token_scoreboard;
		tok_t        expected_tokens[$];
		tok_t        byte_tokens[$];
		int unsigned mismatches;
		string       kw_word[NUM_KW] = '{"int", "print", "if", "string", "array"};
		logic [4:0]  kw_kind[NUM_KW] = '{K_INT, K_PRINT, K_IF, K_STRING, K_ARRAY};
		int          pos;
		int          tbeg;
		mode_t       mode;
		logic [4:0]  cand;

		function new();
			mismatches = 0;
			clear_state();
		endfunction

		function void clear_state();
			pos  = 0;
			tbeg = 0;
			mode = M_IDLE;
			cand = '0;
		endfunction

		function bit is_letter(logic [7:0] b);
			return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
		endfunction

		function bit is_digit(logic [7:0] b);
			return b >= "0" && b <= "9";
		endfunction

		function bit is_blank(logic [7:0] b);
			return b == " " || (b >= 8'd9 && b <= 8'd13);
		endfunction

		function void push(logic [4:0] kind, int s, int len);
			tok_t t;
			t.kind   = kind;
			t.start  = s[15:0];
			t.length = len[15:0];
			t.last   = 1'b0;
			byte_tokens = {byte_tokens, t};
		endfunction

		function int span(int e);
			return (e >= tbeg) ? e - tbeg : 0;
		endfunction

		// keywords still alive once character k of the word is b
		function logic [4:0] keyword_filter(logic [4:0] alive, int k, logic [7:0] b);
			logic [4:0] m;
			m = '0;
			for (int i = 0; i < NUM_KW; i++)
				if (alive[i] && k < kw_word[i].len() && kw_word[i][k] == b)
					m[i] = 1'b1;
			return m;
		endfunction

		function logic [4:0] ident_kind(int len);
			for (int i = 0; i < NUM_KW; i++)
				if (cand[i] && len == kw_word[i].len())
					return kw_kind[i];
			return K_IDENT;
		endfunction

		function void open_token(logic [7:0] b, int p, int np);
			logic [4:0] k;
			k = K_END;
			if (is_blank(b))
				return;
			if (is_letter(b)) begin
				mode = M_IDENT;
				tbeg = p;
				cand = keyword_filter(5'b11111, 0, b);
				return;
			end
			if (is_digit(b)) begin
				mode = M_NUM;
				tbeg = p;
				return;
			end
			case (b)
				"=": begin mode = M_EQ; tbeg = p; end
				"<": begin mode = M_LT; tbeg = p; end
				">": begin mode = M_GT; tbeg = p; end
				"\"": begin mode = M_STR; tbeg = np; end
				"+": k = K_PLUS;
				"-": k = K_MINUS;
				"*": k = K_STAR;
				"/": k = K_SLASH;
				";": k = K_SEMI;
				"(": k = K_LPAREN;
				")": k = K_RPAREN;
				"{": k = K_LBRACE;
				"}": k = K_RBRACE;
				"[": k = K_LBRACK;
				"]": k = K_RBRACK;
				",": k = K_COMMA;
				default: ;
			endcase
			if (k != K_END)
				push(k, p, 1);
		endfunction

		// byte accepted by the block: predict every token it causes
		function void accept_byte(logic [7:0] b, logic eot);
			int         p;
			int         np;
			bit         consumed;
			logic [4:0] single_k;
			logic [4:0] double_k;
			p        = pos;
			np       = (p < POS_SAT) ? p + 1 : POS_SAT;
			consumed = 1'b1;
			byte_tokens.delete();
			case (mode)
				M_IDENT: begin
					if (is_letter(b) || is_digit(b)) begin
						cand = (p >= POS_SAT) ? 5'b0 : keyword_filter(cand, p - tbeg, b);
					end else begin
						push(ident_kind(span(p)), tbeg, span(p));
						mode     = M_IDLE;
						consumed = 1'b0;
					end
				end
				M_NUM: begin
					if (!is_digit(b)) begin
						push(K_NUMBER, tbeg, span(p));
						mode     = M_IDLE;
						consumed = 1'b0;
					end
				end
				M_EQ, M_LT, M_GT: begin
					single_k = (mode == M_EQ) ? K_ASSIGN : (mode == M_LT) ? K_LT : K_GT;
					double_k = (mode == M_EQ) ? K_EQ : (mode == M_LT) ? K_LE : K_GE;
					if (b == "=") begin
						push(double_k, tbeg, 2);
					end else begin
						push(single_k, tbeg, 1);
						consumed = 1'b0;
					end
					mode = M_IDLE;
				end
				M_STR: begin
					if (b == "\"" || b == 8'h00) begin
						push(K_STRLIT, tbeg, span(p));
						mode = M_IDLE;
					end
				end
				default: begin
					mode     = M_IDLE;
					consumed = 1'b0;
				end
			endcase
			if (!consumed)
				open_token(b, p, np);
			if (eot) begin
				case (mode)
					M_IDENT: push(ident_kind(span(np)), tbeg, span(np));
					M_NUM:   push(K_NUMBER, tbeg, span(np));
					M_EQ:    push(K_ASSIGN, tbeg, 1);
					M_LT:    push(K_LT, tbeg, 1);
					M_GT:    push(K_GT, tbeg, 1);
					M_STR:   push(K_STRLIT, tbeg, span(np));
					default: ;
				endcase
				push(K_END, np, 0);
				clear_state();
			end else begin
				pos = np;
			end
			if (byte_tokens.size() > 0)
				byte_tokens[byte_tokens.size() - 1].last = 1'b1;
			foreach (byte_tokens[i])
				expected_tokens = {expected_tokens, byte_tokens[i]};
		endfunction

		function void compare_field(string field, int want, int got);
			if (want != got) begin
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
				mismatches++;
			end
		endfunction

		function void check_token(tok_t got);
			tok_t want;
			if (expected_tokens.size() == 0) begin
				$display("%0t: token with none pending: expected none, actual kind %0d start %0d len %0d",
					$time, got.kind, got.start, got.length);
				mismatches++;
				return;
			end
			want = expected_tokens.pop_front();
			compare_field("token_kind", want.kind, got.kind);
			compare_field("token_start", want.start, got.start);
			compare_field("token_length", want.length, got.length);
			compare_field("last_of_run", want.last, got.last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	stl_text_if  text();
	stl_token_if tokens();

	source_text_tokenizer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.tokens (tokens)
	);

	token_scoreboard sb;
	bit              src_gaps;
	bit              sink_stalls;
	int              idle_cycles;
	int              random_bytes;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin : monitor
		tok_t got;
		if (arst_n) begin
			if (text.valid && text.ready)
				sb.accept_byte(text.text_byte, text.end_of_text);
			if (tokens.valid && tokens.ready) begin
				got.kind   = tokens.token_kind;
				got.start  = tokens.token_start;
				got.length = tokens.token_length;
				got.last   = tokens.last_of_run;
				sb.check_token(got);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((text.valid && text.ready) || (tokens.valid && tokens.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// sink side: random stall bursts while enabled
	initial begin
		tokens.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (sink_stalls && $urandom_range(0, 3) == 0) begin
				tokens.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			tokens.ready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eot);
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			text.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		text.valid       <= 1'b1;
		text.text_byte   <= b;
		text.end_of_text <= eot;
		@(posedge clk);
		while (!text.ready)
			@(posedge clk);
	endtask

	task automatic send_text(input logic [7:0] txt[$]);
		foreach (txt[i])
			send_byte(txt[i], i == txt.size() - 1);
	endtask

	function automatic void push_word(ref logic [7:0] txt[$], input string w);
		for (int i = 0; i < w.len(); i++)
			txt = {txt, 8'(w[i])};
	endfunction

	function automatic logic [7:0] rand_alnum();
		case ($urandom_range(0, 2))
			0:       return 8'($urandom_range("a", "z"));
			1:       return 8'($urandom_range("A", "Z"));
			default: return 8'($urandom_range("0", "9"));
		endcase
	endfunction

	// one lexeme with random content, then maybe a blank
	function automatic void add_piece(ref logic [7:0] txt[$], input bit allow_str);
		string      ops[6] = '{"=", "==", "<", "<=", ">", ">="};
		string      punct  = "+-*/;(){}[],";
		string      junk   = "!@#$%&?\\^|~:.'";
		string      w;
		int         sel;
		logic [7:0] c;
		sel = $urandom_range(0, 99);
		if (!allow_str && sel >= 80 && sel < 90)
			sel = 0;
		if (sel < 15) begin
			push_word(txt, sb.kw_word[$urandom_range(0, NUM_KW - 1)]);
		end else if (sel < 25) begin
			w = sb.kw_word[$urandom_range(0, NUM_KW - 1)];
			case ($urandom_range(0, 2))
				0:       w = w.substr(0, w.len() - 2);
				1:       w = {w, string'(rand_alnum())};
				default: w = w.toupper();
			endcase
			push_word(txt, w);
		end else if (sel < 40) begin
			txt = {txt, 8'($urandom_range(0, 1) ? $urandom_range("a", "z")
				: $urandom_range("A", "Z"))};
			repeat ($urandom_range(0, 6)) txt = {txt, rand_alnum()};
		end else if (sel < 52) begin
			repeat ($urandom_range(1, 6)) txt = {txt, 8'($urandom_range("0", "9"))};
		end else if (sel < 66) begin
			push_word(txt, ops[$urandom_range(0, 5)]);
		end else if (sel < 80) begin
			txt = {txt, 8'(punct[$urandom_range(0, punct.len() - 1)])};
		end else if (sel < 90) begin
			txt = {txt, 8'("\"")};
			repeat ($urandom_range(0, 6)) begin
				do c = 8'($urandom_range(32, 126)); while (c == "\"");
				txt = {txt, c};
			end
			case ($urandom_range(0, 4))
				0:       txt = {txt, 8'h00};
				1:       ;  // left open
				default: txt = {txt, 8'("\"")};
			endcase
		end else begin
			case ($urandom_range(0, 3))
				0:       txt = {txt, 8'h00};
				1:       txt = {txt, 8'($urandom_range(128, 255))};
				2:       txt = {txt, 8'(junk[$urandom_range(0, junk.len() - 1)])};
				default: txt = {txt, 8'($urandom_range(0, 255))};
			endcase
		end
		if ($urandom_range(0, 3) != 0)
			txt = {txt, 8'($urandom_range(0, 2) ? " " : $urandom_range(9, 13))};
	endfunction

	initial begin
		logic [7:0] txt[$];
		sb          = new();
		idle_cycles = 0;
		src_gaps    = 1'b1;
		sink_stalls = 1'b1;
		arst_n           <= 1'b0;
		text.valid       <= 1'b0;
		text.text_byte   <= 8'h00;
		text.end_of_text <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero and 0xFF dropped, x <= 9, string cut by zero, open string at end
		txt = '{8'h00, 8'hFF, "x", "<", "=", "9", "\"", "a", 8'h00, "\"", "q"};
		send_text(txt);
		txt = '{"i", "n", "t", ">"};
		send_text(txt);
		txt = '{"="};
		send_text(txt);
		// ident flush, pending < flush and end token on one byte
		txt = '{"a", "b", "<"};
		send_text(txt);

		random_bytes = 0;
		while (random_bytes < RANDOM_BYTES) begin
			txt.delete();
			repeat ($urandom_range(1, 12)) add_piece(txt, 1'b1);
			if (random_bytes >= CALM_FROM) begin
				src_gaps    = 1'b0;
				sink_stalls = 1'b0;
			end else begin
				src_gaps    = $urandom_range(0, 2) != 0;
				sink_stalls = $urandom_range(0, 2) != 0;
			end
			send_text(txt);
			random_bytes += txt.size();
		end
		text.valid <= 1'b0;

		while (sb.expected_tokens.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_tokens.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
